[rtl/smx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, codes and helpers of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int STACK_DEPTH_DEF = 2048;
    localparam int CODE_DEPTH_DEF  = 512;
    localparam int FRAME_WORDS     = 4;

    // instruction codes
    localparam logic [3:0] OP_LIT = 4'd1;
    localparam logic [3:0] OP_OPR = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_STO = 4'd4;
    localparam logic [3:0] OP_CAL = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JPC = 4'd8;
    localparam logic [3:0] OP_PRT = 4'd9;
    localparam logic [3:0] OP_RD  = 4'd10;
    localparam logic [3:0] OP_HLT = 4'd11;

    // operation numbers of opr
    localparam logic [31:0] OPR_RET = 32'd0;
    localparam logic [31:0] OPR_NEG = 32'd1;
    localparam logic [31:0] OPR_ADD = 32'd2;
    localparam logic [31:0] OPR_SUB = 32'd3;
    localparam logic [31:0] OPR_MUL = 32'd4;
    localparam logic [31:0] OPR_DIV = 32'd5;
    localparam logic [31:0] OPR_ODD = 32'd6;
    localparam logic [31:0] OPR_MOD = 32'd7;
    localparam logic [31:0] OPR_EQL = 32'd8;
    localparam logic [31:0] OPR_NEQ = 32'd9;
    localparam logic [31:0] OPR_LSS = 32'd10;
    localparam logic [31:0] OPR_LEQ = 32'd11;
    localparam logic [31:0] OPR_GTR = 32'd12;
    localparam logic [31:0] OPR_GEQ = 32'd13;

    // fault codes, larger code wins
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_DIV0  = 2'd1;
    localparam logic [1:0] FLT_RANGE = 2'd2;
    localparam logic [1:0] FLT_BAD   = 2'd3;

    typedef enum logic [3:0] {
        CL_LIT, CL_OPR, CL_LOD, CL_STO, CL_CAL, CL_INC,
        CL_JMP, CL_JPC, CL_PRT, CL_RD, CL_HLT, CL_BAD
    } op_class_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_WALK, ST_WALK_WAIT, ST_RD_X, ST_RD_X_WAIT,
        ST_RD_Y, ST_RD_Y_WAIT, ST_EXEC, ST_DIV_WAIT, ST_WRITE,
        ST_PC_MOD, ST_PC_WAIT, ST_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [3:0]         level;
        logic signed [31:0] modifier;
        logic signed [31:0] read_value;
    } in_t;

    typedef struct packed {
        logic [8:0]         next_pc;
        logic [11:0]        base_ptr;
        logic [11:0]        stack_ptr;
        logic               halted;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [1:0]         fault;
    } out_t;

    typedef struct packed {
        in_t       data;
        op_class_t cls;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic        start;
        logic        sgn;
        logic [31:0] dvd;
        logic [31:0] dvs;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;

    function automatic op_class_t classify(input logic [3:0] op);
        op_class_t c;
        case (op)
            OP_LIT: c = CL_LIT;
            OP_OPR: c = CL_OPR;
            OP_LOD: c = CL_LOD;
            OP_STO: c = CL_STO;
            OP_CAL: c = CL_CAL;
            OP_INC: c = CL_INC;
            OP_JMP: c = CL_JMP;
            OP_JPC: c = CL_JPC;
            OP_PRT: c = CL_PRT;
            OP_RD:  c = CL_RD;
            OP_HLT: c = CL_HLT;
            default: c = CL_BAD;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] fault_max(input logic [1:0] a, input logic [1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

[rtl/smx_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                     aclk,
    input  wire                     wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]         wr_data,
    input  wire                     rd_en,
    input  wire [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/smx_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_div
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
module smx_div (
    input  wire               aclk,
    input  wire               aresetn,
    input  smx_pkg::div_req_t req,
    output smx_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one restoring step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        shifted   = {rem_reg, quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = '0;
            quo_next  = (req.sgn && req.dvd[31]) ? -req.dvd : req.dvd;
            dvs_next  = (req.sgn && req.dvs[31]) ? -req.dvs : req.dvs;
            negq_next = req.sgn && (req.dvd[31] ^ req.dvs[31]);
            negr_next = req.sgn && req.dvd[31];
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    // sign fix of the results
    always_comb begin
        rsp.done = done_reg;
        rsp.quo  = negq_reg ? -quo_reg : quo_reg;
        rsp.rem  = negr_reg ? -rem_reg : rem_reg;
    end

`ifndef NO_ASSERTIONS
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start) else $error("divider started while busy");
    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg)) else $error("stray divider done");
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 6'd0 && cnt_reg <= 6'd32) else $error("bad step count");
`endif

endmodule
`default_nettype wire

[rtl/smx_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_front
// Accepts instruction words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module smx_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  smx_pkg::in_t        s_data,
    output smx_pkg::q_head_t    head,
    input  wire                 pop
);

    smx_pkg::q_entry_t e0_reg, e1_reg;
    logic              wptr_reg, rptr_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push;
    smx_pkg::q_entry_t ent;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;

    // classify the incoming word
    always_comb begin
        ent.data = s_data;
        ent.cls  = smx_pkg::classify(s_data.opcode);
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // queue storage and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
        end
        if (push && !wptr_reg) begin
            e0_reg <= ent;
        end
        if (push && wptr_reg) begin
            e1_reg <= ent;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = rptr_reg ? e1_reg : e0_reg;

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> cnt_reg != 2'd2) else $error("push into full queue");
`endif

endmodule
`default_nettype wire

[rtl/smx_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_back
// Sequencer that carries out one instruction against the stack memory.
// ----------------------------------------------------------------------------
module smx_back #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = smx_pkg::CODE_DEPTH_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  smx_pkg::q_head_t head,
    output logic             pop,
    output logic             m_valid,
    input  wire              m_ready,
    output smx_pkg::out_t    m_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int PCW = $clog2(CODE_DEPTH);

    smx_pkg::state_t   state_reg, state_next;
    smx_pkg::q_entry_t cur_reg, cur_next;
    logic [3:0]        hops_reg, hops_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       xaddr_reg, xaddr_next;
    logic [31:0]       yaddr_reg, yaddr_next;
    logic              rdok_reg, rdok_next;
    logic [31:0]       x_reg, x_next;
    logic [31:0]       y_reg, y_next;
    logic [31:0]       res_reg, res_next;
    logic [31:0]       psrc_reg, psrc_next;
    logic [1:0]        wcnt_reg, wcnt_next;
    logic [1:0]        fault_reg, fault_next;
    logic              prt_reg, prt_next;
    logic [31:0]       pval_reg, pval_next;
    logic [PCW-1:0]    wpc_reg, wpc_next;
    logic [11:0]       wbp_reg, wbp_next;
    logic [11:0]       wsp_reg, wsp_next;
    logic              whalt_reg, whalt_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [PCW-1:0]    pc_reg, pc_next;
    logic [11:0]       bp_reg, bp_next;
    logic [11:0]       sp_reg, sp_next;
    logic              halt_reg, halt_next;
    logic              mv_reg, mv_next;
    smx_pkg::out_t     md_reg, md_next;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_idx, rd_idx;
    logic [31:0]       wr_data, rd_data;
    logic [31:0]       waddr;
    logic              wlast;
    smx_pkg::div_req_t dreq;
    smx_pkg::div_rsp_t drsp;

    logic [31:0]       sp32, bp32, mod_u;
    logic [PCW-1:0]    pc_inc;
    smx_pkg::q_entry_t hd;

    assign sp32   = 32'(sp_reg);
    assign bp32   = 32'(bp_reg);
    assign mod_u  = cur_reg.data.modifier;
    assign hd     = head.entry;
    assign pc_inc = (pc_reg == PCW'(CODE_DEPTH - 1)) ? '0 : pc_reg + PCW'(1);

    smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    smx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // write address and data of the current write step
    always_comb begin
        waddr   = 32'(sp_reg + 12'd1);
        wr_data = res_reg;
        wlast   = 1'b1;
        case (cur_reg.cls)
            smx_pkg::CL_STO: begin
                waddr   = (wcnt_reg == 2'd0) ? base_reg + mod_u : sp32;
                wr_data = (wcnt_reg == 2'd0) ? x_reg : 32'd0;
                wlast   = (wcnt_reg == 2'd1);
            end
            smx_pkg::CL_CAL: begin
                waddr = sp32 + 32'(wcnt_reg) + 32'd1;
                case (wcnt_reg)
                    2'd0:    wr_data = 32'd0;
                    2'd1:    wr_data = base_reg;
                    2'd2:    wr_data = bp32;
                    default: wr_data = 32'(pc_reg) + 32'd1;
                endcase
                wlast = (wcnt_reg == 2'd3);
            end
            smx_pkg::CL_OPR: begin
                waddr = (mod_u == smx_pkg::OPR_NEG || mod_u == smx_pkg::OPR_ODD) ?
                        sp32 : sp32 - 32'd1;
            end
            default: begin
                // push goes to the wrapped new top
                waddr = 32'(sp_reg + 12'd1);
            end
        endcase
        // clearing pass writes zeros
        if (state_reg == smx_pkg::ST_CLEAR) begin
            wr_data = 32'd0;
        end
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        hops_next  = hops_reg;
        base_next  = base_reg;
        xaddr_next = xaddr_reg;
        yaddr_next = yaddr_reg;
        rdok_next  = rdok_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        res_next   = res_reg;
        psrc_next  = psrc_reg;
        wcnt_next  = wcnt_reg;
        fault_next = fault_reg;
        prt_next   = prt_reg;
        pval_next  = pval_reg;
        wpc_next   = wpc_reg;
        wbp_next   = wbp_reg;
        wsp_next   = wsp_reg;
        whalt_next = whalt_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        bp_next    = bp_reg;
        sp_next    = sp_reg;
        halt_next  = halt_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = waddr[AW-1:0];
        rd_en      = 1'b0;
        rd_idx     = xaddr_reg[AW-1:0];
        dreq.start = 1'b0;
        dreq.sgn   = 1'b0;
        dreq.dvd   = x_reg;
        dreq.dvs   = y_reg;

        case (state_reg)
            // zero the stack memory after reset
            smx_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_idx  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(STACK_DEPTH - 1)) begin
                    state_next = smx_pkg::ST_IDLE;
                end
            end

            // take the next word from the queue
            smx_pkg::ST_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    cur_next   = hd;
                    hops_next  = hd.data.level;
                    base_next  = bp32;
                    fault_next = smx_pkg::FLT_NONE;
                    prt_next   = 1'b0;
                    pval_next  = 32'd0;
                    wcnt_next  = 2'd0;
                    wpc_next   = pc_reg;
                    wbp_next   = bp_reg;
                    wsp_next   = sp_reg;
                    whalt_next = halt_reg;
                    xaddr_next = sp32;
                    yaddr_next = sp32;
                    if (halt_reg) begin
                        state_next = smx_pkg::ST_DONE;
                    end else begin
                        case (hd.cls)
                            smx_pkg::CL_LOD, smx_pkg::CL_STO, smx_pkg::CL_CAL: begin
                                state_next = smx_pkg::ST_WALK;
                            end
                            smx_pkg::CL_JPC, smx_pkg::CL_PRT: begin
                                state_next = smx_pkg::ST_RD_X;
                            end
                            smx_pkg::CL_OPR: begin
                                if (hd.data.modifier == smx_pkg::OPR_RET) begin
                                    xaddr_next = bp32 - 32'd1 + 32'(smx_pkg::FRAME_WORDS);
                                    yaddr_next = bp32 - 32'd1 + 32'd3;
                                    state_next = smx_pkg::ST_RD_X;
                                end else if (hd.data.modifier == smx_pkg::OPR_NEG ||
                                             hd.data.modifier == smx_pkg::OPR_ODD) begin
                                    state_next = smx_pkg::ST_RD_X;
                                end else if (hd.data.modifier >= smx_pkg::OPR_ADD &&
                                             hd.data.modifier <= smx_pkg::OPR_GEQ) begin
                                    xaddr_next = sp32 - 32'd1;
                                    state_next = smx_pkg::ST_RD_X;
                                end else begin
                                    fault_next = smx_pkg::FLT_BAD;
                                    wpc_next   = pc_inc;
                                    state_next = smx_pkg::ST_DONE;
                                end
                            end
                            default: begin
                                state_next = smx_pkg::ST_EXEC;
                            end
                        endcase
                    end
                end
            end

            // follow static links, one stack read per hop
            smx_pkg::ST_WALK: begin
                if (hops_reg == 4'd0) begin
                    case (cur_reg.cls)
                        smx_pkg::CL_LOD: begin
                            xaddr_next = base_reg + mod_u;
                            state_next = smx_pkg::ST_RD_X;
                        end
                        smx_pkg::CL_STO: state_next = smx_pkg::ST_RD_X;
                        default:         state_next = smx_pkg::ST_EXEC;
                    endcase
                end else begin
                    rd_idx    = base_reg[AW-1:0] + AW'(1);
                    rdok_next = (base_reg + 32'd1) < 32'(STACK_DEPTH);
                    rd_en     = rdok_next;
                    state_next = smx_pkg::ST_WALK_WAIT;
                end
            end

            smx_pkg::ST_WALK_WAIT: begin
                base_next = rdok_reg ? rd_data : 32'd0;
                if (!rdok_reg) begin
                    fault_next = smx_pkg::fault_max(fault_reg, smx_pkg::FLT_RANGE);
                end
                hops_next  = hops_reg - 4'd1;
                state_next = smx_pkg::ST_WALK;
            end

            // operand reads
            smx_pkg::ST_RD_X: begin
                rd_idx     = xaddr_reg[AW-1:0];
                rdok_next  = xaddr_reg < 32'(STACK_DEPTH);
                rd_en      = rdok_next;
                state_next = smx_pkg::ST_RD_X_WAIT;
            end

            smx_pkg::ST_RD_X_WAIT: begin
                x_next = rdok_reg ? rd_data : 32'd0;
                if (!rdok_reg) begin
                    fault_next = smx_pkg::fault_max(fault_reg, smx_pkg::FLT_RANGE);
                end
                if (cur_reg.cls == smx_pkg::CL_OPR && mod_u != smx_pkg::OPR_NEG &&
                    mod_u != smx_pkg::OPR_ODD) begin
                    state_next = smx_pkg::ST_RD_Y;
                end else begin
                    state_next = smx_pkg::ST_EXEC;
                end
            end

            smx_pkg::ST_RD_Y: begin
                rd_idx     = yaddr_reg[AW-1:0];
                rdok_next  = yaddr_reg < 32'(STACK_DEPTH);
                rd_en      = rdok_next;
                state_next = smx_pkg::ST_RD_Y_WAIT;
            end

            smx_pkg::ST_RD_Y_WAIT: begin
                y_next = rdok_reg ? rd_data : 32'd0;
                if (!rdok_reg) begin
                    fault_next = smx_pkg::fault_max(fault_reg, smx_pkg::FLT_RANGE);
                end
                state_next = smx_pkg::ST_EXEC;
            end

            // compute results and register updates
            smx_pkg::ST_EXEC: begin
                state_next = smx_pkg::ST_DONE;
                psrc_next  = mod_u;
                case (cur_reg.cls)
                    smx_pkg::CL_LIT, smx_pkg::CL_RD, smx_pkg::CL_LOD: begin
                        res_next = (cur_reg.cls == smx_pkg::CL_LIT) ? mod_u :
                                   (cur_reg.cls == smx_pkg::CL_RD) ?
                                   cur_reg.data.read_value : x_reg;
                        wsp_next   = sp_reg + 12'd1;
                        wpc_next   = pc_inc;
                        state_next = smx_pkg::ST_WRITE;
                    end
                    smx_pkg::CL_STO: begin
                        wsp_next   = sp_reg - 12'd1;
                        wpc_next   = pc_inc;
                        state_next = smx_pkg::ST_WRITE;
                    end
                    smx_pkg::CL_CAL: begin
                        wbp_next   = sp_reg + 12'd1;
                        state_next = smx_pkg::ST_WRITE;
                    end
                    smx_pkg::CL_INC: begin
                        wsp_next = sp_reg + mod_u[11:0];
                        wpc_next = pc_inc;
                    end
                    smx_pkg::CL_JMP: begin
                        state_next = smx_pkg::ST_PC_MOD;
                    end
                    smx_pkg::CL_JPC: begin
                        wsp_next = sp_reg - 12'd1;
                        if (x_reg == 32'd0) begin
                            state_next = smx_pkg::ST_PC_MOD;
                        end else begin
                            wpc_next = pc_inc;
                        end
                    end
                    smx_pkg::CL_PRT: begin
                        prt_next  = 1'b1;
                        pval_next = x_reg;
                        wsp_next  = sp_reg - 12'd1;
                        wpc_next  = pc_inc;
                    end
                    smx_pkg::CL_HLT: begin
                        whalt_next = 1'b1;
                        wpc_next   = '0;
                        wbp_next   = '0;
                        wsp_next   = '0;
                    end
                    smx_pkg::CL_OPR: begin
                        wpc_next   = pc_inc;
                        wsp_next   = sp_reg - 12'd1;
                        state_next = smx_pkg::ST_WRITE;
                        case (mod_u)
                            smx_pkg::OPR_RET: begin
                                wsp_next   = bp_reg - 12'd1;
                                wbp_next   = y_reg[11:0];
                                psrc_next  = x_reg;
                                state_next = smx_pkg::ST_PC_MOD;
                            end
                            smx_pkg::OPR_NEG: begin
                                res_next = -x_reg;
                                wsp_next = sp_reg;
                            end
                            smx_pkg::OPR_ODD: begin
                                res_next = {31'd0, x_reg[0]};
                                wsp_next = sp_reg;
                            end
                            smx_pkg::OPR_ADD: res_next = x_reg + y_reg;
                            smx_pkg::OPR_SUB: res_next = x_reg - y_reg;
                            smx_pkg::OPR_MUL: res_next = x_reg * y_reg;
                            smx_pkg::OPR_DIV, smx_pkg::OPR_MOD: begin
                                if (y_reg == 32'd0) begin
                                    res_next   = 32'd0;
                                    fault_next = smx_pkg::fault_max(fault_reg,
                                                                    smx_pkg::FLT_DIV0);
                                end else begin
                                    dreq.start = 1'b1;
                                    dreq.sgn   = 1'b1;
                                    dreq.dvd   = x_reg;
                                    dreq.dvs   = y_reg;
                                    state_next = smx_pkg::ST_DIV_WAIT;
                                end
                            end
                            smx_pkg::OPR_EQL: res_next = {31'd0, x_reg == y_reg};
                            smx_pkg::OPR_NEQ: res_next = {31'd0, x_reg != y_reg};
                            smx_pkg::OPR_LSS: res_next = {31'd0, $signed(x_reg) < $signed(y_reg)};
                            smx_pkg::OPR_LEQ: res_next = {31'd0, $signed(x_reg) <= $signed(y_reg)};
                            smx_pkg::OPR_GTR: res_next = {31'd0, $signed(x_reg) > $signed(y_reg)};
                            default:          res_next = {31'd0, $signed(x_reg) >= $signed(y_reg)};
                        endcase
                    end
                    default: begin
                        fault_next = smx_pkg::FLT_BAD;
                    end
                endcase
            end

            smx_pkg::ST_DIV_WAIT: begin
                if (drsp.done) begin
                    res_next   = (mod_u == smx_pkg::OPR_DIV) ? drsp.quo : drsp.rem;
                    state_next = smx_pkg::ST_WRITE;
                end
            end

            // one stack write per cycle
            smx_pkg::ST_WRITE: begin
                wr_en = waddr < 32'(STACK_DEPTH);
                if (!wr_en) begin
                    fault_next = smx_pkg::fault_max(fault_reg, smx_pkg::FLT_RANGE);
                end
                wcnt_next = wcnt_reg + 2'd1;
                if (wlast) begin
                    state_next = (cur_reg.cls == smx_pkg::CL_CAL) ?
                                 smx_pkg::ST_PC_MOD : smx_pkg::ST_DONE;
                end
            end

            // new pc modulo the code depth, a power of two, so the low bits
            smx_pkg::ST_PC_MOD: begin
                wpc_next   = psrc_reg[PCW-1:0];
                state_next = smx_pkg::ST_DONE;
            end

            // commit and hand the result word to the output register
            smx_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    pc_next             = wpc_reg;
                    bp_next             = wbp_reg;
                    sp_next             = wsp_reg;
                    halt_next           = whalt_reg;
                    mv_next             = 1'b1;
                    md_next.next_pc     = 9'(wpc_reg);
                    md_next.base_ptr    = wbp_reg;
                    md_next.stack_ptr   = wsp_reg;
                    md_next.halted      = whalt_reg;
                    md_next.print_valid = prt_reg;
                    md_next.print_value = pval_reg;
                    md_next.fault       = fault_reg;
                    state_next          = smx_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = smx_pkg::ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smx_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            bp_reg    <= 12'd1;
            sp_reg    <= '0;
            halt_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            bp_reg    <= bp_next;
            sp_reg    <= sp_next;
            halt_reg  <= halt_next;
            mv_reg    <= mv_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        hops_reg  <= hops_next;
        base_reg  <= base_next;
        xaddr_reg <= xaddr_next;
        yaddr_reg <= yaddr_next;
        rdok_reg  <= rdok_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        res_reg   <= res_next;
        psrc_reg  <= psrc_next;
        wcnt_reg  <= wcnt_next;
        fault_reg <= fault_next;
        prt_reg   <= prt_next;
        pval_reg  <= pval_next;
        wpc_reg   <= wpc_next;
        wbp_reg   <= wbp_next;
        wsp_reg   <= wsp_next;
        whalt_reg <= whalt_next;
        md_reg    <= md_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

`ifndef NO_ASSERTIONS
    a_wr_states: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == smx_pkg::ST_CLEAR || state_reg == smx_pkg::ST_WRITE)
        else $error("stack write outside write states");
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg) else $error("halt flag dropped");
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PCW'(CODE_DEPTH - 1)) else $error("pc beyond code depth");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == smx_pkg::ST_IDLE) else $error("pop outside idle");
`endif

endmodule
`default_nettype wire

[rtl/stack_machine_executor_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// PL/0 P-machine executor: one instruction word in, one status word out.
// ----------------------------------------------------------------------------
// After reset the core sweeps the whole stack memory to zero, one word per
// cycle, before it executes anything; words are queued meanwhile. In the
// back end every stack read goes through the single read port and is
// registered, each static link hop is one stack read, and divide and modulo
// run through the iterative divider; an instruction may also wait on the
// output. New pc values are reduced by keeping the low bits, so CODE_DEPTH
// must be a power of two. A two-entry input queue and the output register
// let the neighbors run while an instruction executes.
module stack_machine_executor_core #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = smx_pkg::CODE_DEPTH_DEF
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    input  smx_pkg::in_t  s_data,
    output logic          m_valid,
    input  wire           m_ready,
    output smx_pkg::out_t m_data
);

    smx_pkg::q_head_t head;
    logic             pop;

    // front: accept and classify
    smx_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .head    (head),
        .pop     (pop)
    );

    // back: execute
    smx_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .CODE_DEPTH  (CODE_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

[tb/sv/tb_stack_machine_executor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_machine_executor_core
// Self-checking bench for the P-machine executor core. A behavioral copy of
// the machine (stack store, pc, bp, sp, halt) predicts the status word of each
// accepted instruction word; a monitor compares every returned word field by
// field. Directed words cover every instruction but halt, every operation and the
// corner cases; random instruction streams follow under varying idle
// patterns, a long output hold-off and a full drain, and halt ends the run.
// ----------------------------------------------------------------------------
module tb_stack_machine_executor_core;

    localparam int DEPTH = smx_pkg::STACK_DEPTH_DEF;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    smx_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    smx_pkg::out_t m_data;

    stack_machine_executor_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // machine copy used for prediction
    logic [31:0] stk [0:DEPTH-1];
    logic [31:0] pc_q;
    logic [31:0] bp_q;
    logic [31:0] sp_q;
    logic        halt_q;
    logic [1:0]  step_flt;
    int          call_depth;

    smx_pkg::out_t status_q[$];
    int            errors;
    int            tx_idle;
    int            rx_idle;
    int            hold_cnt;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void raise(input logic [1:0] code);
        if (code > step_flt)
            step_flt = code;
    endfunction

    function automatic logic [31:0] rd_word(input logic [31:0] a);
        if (a < DEPTH)
            return stk[a];
        raise(smx_pkg::FLT_RANGE);
        return 32'd0;
    endfunction

    function automatic void wr_word(input logic [31:0] a, input logic [31:0] v);
        if (a < DEPTH)
            stk[a] = v;
        else
            raise(smx_pkg::FLT_RANGE);
    endfunction

    function automatic logic [31:0] walk_base(input logic [3:0] hops);
        logic [31:0] b;
        b = bp_q;
        for (int i = 0; i < hops; i++)
            b = rd_word(b + 32'd1);
        return b;
    endfunction

    function automatic void exec_opr(input logic [31:0] op);
        logic [31:0] below;
        logic [31:0] frame;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] r;
        longint      a;
        longint      b;
        below = sp_q - 32'd1;
        r = 32'd0;
        if (op == smx_pkg::OPR_RET) begin
            frame = bp_q - 32'd1;
            sp_q  = frame & 32'hFFF;
            pc_q  = rd_word(frame + 32'(smx_pkg::FRAME_WORDS)) % 512;
            bp_q  = rd_word(frame + 32'd3) & 32'hFFF;
            return;
        end
        if (op == smx_pkg::OPR_NEG) begin
            wr_word(sp_q, 32'd0 - rd_word(sp_q));
        end else if (op == smx_pkg::OPR_ODD) begin
            wr_word(sp_q, rd_word(sp_q) & 32'd1);
        end else if (op >= smx_pkg::OPR_ADD && op <= smx_pkg::OPR_GEQ) begin
            x = rd_word(below);
            y = rd_word(sp_q);
            a = longint'($signed(x));
            b = longint'($signed(y));
            case (op)
                smx_pkg::OPR_ADD: r = x + y;
                smx_pkg::OPR_SUB: r = x - y;
                smx_pkg::OPR_MUL: r = x * y;
                smx_pkg::OPR_DIV: begin
                    if (b == 0) raise(smx_pkg::FLT_DIV0);
                    else r = 32'(a / b);
                end
                smx_pkg::OPR_MOD: begin
                    if (b == 0) raise(smx_pkg::FLT_DIV0);
                    else r = 32'(a % b);
                end
                smx_pkg::OPR_EQL: r = {31'd0, a == b};
                smx_pkg::OPR_NEQ: r = {31'd0, a != b};
                smx_pkg::OPR_LSS: r = {31'd0, a < b};
                smx_pkg::OPR_LEQ: r = {31'd0, a <= b};
                smx_pkg::OPR_GTR: r = {31'd0, a > b};
                default: r = {31'd0, a >= b};
            endcase
            wr_word(below, r);
            sp_q = below & 32'hFFF;
        end else begin
            raise(smx_pkg::FLT_BAD);
        end
        pc_q = (pc_q + 32'd1) % 512;
    endfunction

    function automatic smx_pkg::out_t predict_status(input smx_pkg::in_t w);
        smx_pkg::out_t o;
        logic [31:0]   m;
        logic [31:0]   base;
        logic [31:0]   v;
        m = w.modifier;
        o = '0;
        step_flt = smx_pkg::FLT_NONE;
        if (!halt_q) begin
            case (w.opcode)
                smx_pkg::OP_LIT: begin
                    sp_q = (sp_q + 32'd1) & 32'hFFF;
                    wr_word(sp_q, m);
                    pc_q = (pc_q + 32'd1) % 512;
                end
                smx_pkg::OP_OPR: exec_opr(m);
                smx_pkg::OP_LOD: begin
                    base = walk_base(w.level);
                    sp_q = (sp_q + 32'd1) & 32'hFFF;
                    wr_word(sp_q, rd_word(base + m));
                    pc_q = (pc_q + 32'd1) % 512;
                end
                smx_pkg::OP_STO: begin
                    base = walk_base(w.level);
                    wr_word(base + m, rd_word(sp_q));
                    wr_word(sp_q, 32'd0);
                    sp_q = (sp_q - 32'd1) & 32'hFFF;
                    pc_q = (pc_q + 32'd1) % 512;
                end
                smx_pkg::OP_CAL: begin
                    base = walk_base(w.level);
                    wr_word(sp_q + 32'd1, 32'd0);
                    wr_word(sp_q + 32'd2, base);
                    wr_word(sp_q + 32'd3, bp_q);
                    wr_word(sp_q + 32'(smx_pkg::FRAME_WORDS), pc_q + 32'd1);
                    bp_q = (sp_q + 32'd1) & 32'hFFF;
                    pc_q = m % 512;
                end
                smx_pkg::OP_INC: begin
                    sp_q = (sp_q + m) & 32'hFFF;
                    pc_q = (pc_q + 32'd1) % 512;
                end
                smx_pkg::OP_JMP: pc_q = m % 512;
                smx_pkg::OP_JPC: begin
                    if (rd_word(sp_q) == 32'd0) pc_q = m % 512;
                    else pc_q = (pc_q + 32'd1) % 512;
                    sp_q = (sp_q - 32'd1) & 32'hFFF;
                end
                smx_pkg::OP_PRT: begin
                    v = rd_word(sp_q);
                    o.print_valid = 1'b1;
                    o.print_value = v;
                    sp_q = (sp_q - 32'd1) & 32'hFFF;
                    pc_q = (pc_q + 32'd1) % 512;
                end
                smx_pkg::OP_RD: begin
                    sp_q = (sp_q + 32'd1) & 32'hFFF;
                    wr_word(sp_q, w.read_value);
                    pc_q = (pc_q + 32'd1) % 512;
                end
                smx_pkg::OP_HLT: begin
                    halt_q = 1'b1;
                    pc_q = 32'd0;
                    sp_q = 32'd0;
                    bp_q = 32'd0;
                end
                default: raise(smx_pkg::FLT_BAD);
            endcase
        end
        o.next_pc   = pc_q[8:0];
        o.base_ptr  = bp_q[11:0];
        o.stack_ptr = sp_q[11:0];
        o.halted    = halt_q;
        o.fault     = step_flt;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic smx_pkg::in_t mk(input logic [3:0] op, input logic [3:0] lvl,
                                        input logic [31:0] m, input logic [31:0] rv);
        smx_pkg::in_t w;
        w.opcode     = op;
        w.level      = lvl;
        w.modifier   = m;
        w.read_value = rv;
        return w;
    endfunction

    function automatic logic [31:0] pick_literal();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed instruction words, steered by the predicted stack
    function automatic smx_pkg::in_t next_word();
        int k;
        if (sp_q < 3)
            return mk(smx_pkg::OP_LIT, 4'd0, pick_literal(), $urandom);
        if (sp_q > 1800)
            return mk(smx_pkg::OP_INC, 4'd0, -32'sd200, $urandom);
        k = $urandom_range(99);
        if (k < 14) return mk(smx_pkg::OP_LIT, 4'($urandom), pick_literal(), $urandom);
        if (k < 20) return mk(smx_pkg::OP_RD, 4'($urandom), $urandom, pick_literal());
        if (k < 40)
            return mk(smx_pkg::OP_OPR, 4'($urandom), $urandom_range(1, 13), $urandom);
        if (k < 48)
            return mk(smx_pkg::OP_LOD, 4'($urandom_range(2)), $urandom_range(8), $urandom);
        if (k < 55)
            return mk(smx_pkg::OP_STO, 4'($urandom_range(2)), $urandom_range(8), $urandom);
        if (k < 61) begin
            call_depth++;
            return mk(smx_pkg::OP_CAL, 4'($urandom_range(2)), $urandom, $urandom);
        end
        if (k < 67 && call_depth > 0) begin
            call_depth--;
            return mk(smx_pkg::OP_OPR, 4'($urandom), smx_pkg::OPR_RET, $urandom);
        end
        if (k < 72)
            return mk(smx_pkg::OP_INC, 4'($urandom), $urandom_range(8) - 3, $urandom);
        if (k < 75) return mk(smx_pkg::OP_JMP, 4'($urandom), $urandom, $urandom);
        if (k < 79) return mk(smx_pkg::OP_JPC, 4'($urandom), $urandom, $urandom);
        if (k < 88) return mk(smx_pkg::OP_PRT, 4'($urandom), $urandom, $urandom);
        // noise: any opcode but halt, any level and modifier
        k = $urandom_range(15);
        if (k == smx_pkg::OP_HLT) k = 0;
        return mk(4'(k), 4'($urandom), $urandom, $urandom);
    endfunction

    // one word over the input channel, entered and left at a falling edge
    task automatic send_word(input smx_pkg::in_t w);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        status_q.push_back(predict_status(w));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (status_q.size() != 0) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        smx_pkg::in_t d[$];
        // opr below an empty stack reads out of range, then recover
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, smx_pkg::OPR_ADD, 32'd0));
        d.push_back(mk(smx_pkg::OP_INC, 4'd0, 32'd1, 32'd0));
        d.push_back(mk(smx_pkg::OP_LIT, 4'd0, 32'h8000_0000, 32'd0));
        d.push_back(mk(smx_pkg::OP_LIT, 4'd0, 32'hFFFF_FFFF, 32'd0));
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, smx_pkg::OPR_DIV, 32'd0));  // min over -1
        d.push_back(mk(smx_pkg::OP_LIT, 4'd0, 32'd0, 32'd0));
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, smx_pkg::OPR_MOD, 32'd0));  // modulo by zero
        d.push_back(mk(smx_pkg::OP_RD, 4'd15, 32'd0, 32'hFFFF_FFFD));
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, smx_pkg::OPR_ODD, 32'd0));  // odd of negative
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, smx_pkg::OPR_NEG, 32'd0));
        for (int op = 2; op <= 13; op++) begin
            d.push_back(mk(smx_pkg::OP_RD, 4'd0, 32'd0, 32'(op) - 32'd7));
            d.push_back(mk(smx_pkg::OP_OPR, 4'd0, 32'(op), 32'd0));
        end
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, 32'd14, 32'd0));   // unknown operation
        d.push_back(mk(4'd0, 4'd0, 32'd0, 32'd0));               // unknown opcode
        d.push_back(mk(4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        d.push_back(mk(smx_pkg::OP_CAL, 4'd15, 32'd600, 32'd0));
        d.push_back(mk(smx_pkg::OP_LIT, 4'd0, 32'd42, 32'd0));
        d.push_back(mk(smx_pkg::OP_STO, 4'd1, 32'd3, 32'd0));    // store clears the top
        d.push_back(mk(smx_pkg::OP_LOD, 4'd15, 32'h7FFF_FFFF, 32'd0));
        d.push_back(mk(smx_pkg::OP_JPC, 4'd0, 32'd300, 32'd0));
        d.push_back(mk(smx_pkg::OP_PRT, 4'd0, 32'd0, 32'd0));
        d.push_back(mk(smx_pkg::OP_JMP, 4'd0, 32'hFFFF_FFFF, 32'd0));
        d.push_back(mk(smx_pkg::OP_OPR, 4'd0, smx_pkg::OPR_RET, 32'd0));
        d.push_back(mk(smx_pkg::OP_INC, 4'd0, 32'd2047, 32'd0));
        d.push_back(mk(smx_pkg::OP_LIT, 4'd0, 32'd1, 32'd0));    // write past the store
        d.push_back(mk(smx_pkg::OP_INC, 4'd0, 32'h8000_0000, 32'd0));
        foreach (d[i]) send_word(d[i]);
        wait_drained();
    endtask

    task automatic test_random(input int n, input int tx, input int rx);
        tx_idle = tx;
        rx_idle = rx;
        repeat (n) send_word(next_word());
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle  = 0;
        rx_idle  = 0;
        hold_cnt = 400;
        repeat (20) send_word(next_word());
        wait_drained();
    endtask

    task automatic test_halt();
        send_word(mk(smx_pkg::OP_HLT, 4'd0, 32'd0, 32'd0));
        repeat (4) send_word(next_word());
        send_word(mk(smx_pkg::OP_HLT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $realtime, name, exp_v,
                     act_v);
        end
    endfunction

    always @(posedge aclk) begin
        smx_pkg::out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none actual %h", $realtime, m_data);
            end else begin
                e = status_q.pop_front();
                check_field("next_pc", 32'(e.next_pc), 32'(m_data.next_pc));
                check_field("base_ptr", 32'(e.base_ptr), 32'(m_data.base_ptr));
                check_field("stack_ptr", 32'(e.stack_ptr), 32'(m_data.stack_ptr));
                check_field("halted", 32'(e.halted), 32'(m_data.halted));
                check_field("print_valid", 32'(e.print_valid), 32'(m_data.print_valid));
                check_field("print_value", e.print_value, m_data.print_value);
                check_field("fault", 32'(e.fault), 32'(m_data.fault));
            end
        end
    end

    // receiver with random idling and a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        hold_cnt   = 0;
        errors     = 0;
        tx_idle    = 0;
        rx_idle    = 0;
        call_depth = 0;
        for (int i = 0; i < DEPTH; i++) stk[i] = 32'd0;
        pc_q   = 32'd0;
        bp_q   = 32'd1;
        sp_q   = 32'd0;
        halt_q = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(310, 23, 45);
        test_backpressure();
        test_random(310, 45, 23);
        test_random(310, 0, 0);
        test_halt();

        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[stack_machine_executor_core.f]
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_div.sv
rtl/smx_front.sv
rtl/smx_back.sv
rtl/stack_machine_executor_core.sv
tb/sv/tb_stack_machine_executor_core.sv
